[rtl/srtf_pkg.sv]
// shared types, codes and default sizes of the srtf task scheduler
// used by the controller, the datapath, the top level and the checker
`timescale 1ns / 1ps

package srtf_pkg;

    // default sizes
    localparam int DEF_TASK_SLOTS      = 16;
    localparam int DEF_PRIORITY_LEVELS = 8;

    // field widths
    localparam int ID_W   = 8;
    localparam int TIME_W = 16;
    localparam int PRIO_W = 4;
    localparam int TA_W   = 17;
    localparam int STAT_W = 3;

    // beat widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // input kind carried on s_tuser
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // result status carried on m_tuser
    localparam logic [STAT_W-1:0] STATUS_ADDED    = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_IDLE     = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_RAN      = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_FINISHED = 3'd4;

    // register index
    localparam logic REG_USE_PRIORITY = 1'b0;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // one task table entry
    typedef struct packed {
        logic [PRIO_W-1:0] priority_lvl;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] arrival;
        logic [ID_W-1:0]   task_id;
    } slot_entry_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/srtf_ctrl.sv]
// sequencing state machine of the srtf task scheduler
// depends on srtf_pkg for the command and status structs
`timescale 1ns / 1ps

module srtf_ctrl
    import srtf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  dp_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        dp_cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    dp_cmd.start = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                dp_cmd.scan = 1'b1;
                if (dp_status.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for the result register to drain
                if (dp_status.out_free) begin
                    dp_cmd.finish = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/srtf_datapath.sv]
// task table, slot scan, time counter and result register of the scheduler
// depends on srtf_pkg; driven by srtf_ctrl through ctrl_cmd_t
`timescale 1ns / 1ps

module srtf_datapath
    import srtf_pkg::*;
#(
    parameter int TASK_SLOTS      = DEF_TASK_SLOTS,
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_cmd_t         dp_cmd,
    output dp_status_t        dp_status,
    input  logic              use_priority,
    input  logic              in_cmd,
    input  logic [ID_W-1:0]   in_task_id,
    input  logic [TIME_W-1:0] in_arrival,
    input  logic [TIME_W-1:0] in_burst,
    input  logic [PRIO_W-1:0] in_priority,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [STAT_W-1:0] out_status,
    output logic [ID_W-1:0]   out_task_id,
    output logic [TIME_W-1:0] out_remaining,
    output logic [TA_W-1:0]   out_turnaround,
    output logic [TIME_W-1:0] out_tick_time
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(TASK_SLOTS);
    localparam logic [PRIO_W-1:0] PRIO_TOP = PRIO_W'(PRIORITY_LEVELS);

    // task table
    slot_entry_t mem [TASK_SLOTS];
    slot_entry_t rd_entry_reg;
    logic        mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_entry_t mem_wdata;

    logic [TASK_SLOTS-1:0] slot_valid_reg;
    logic [TIME_W-1:0]     time_reg;

    // latched item
    logic              cmd_reg;
    logic [ID_W-1:0]   task_id_reg;
    logic [TIME_W-1:0] arrival_reg;
    logic [TIME_W-1:0] burst_reg;
    logic [PRIO_W-1:0] prio_reg;

    // scan
    logic [CNT_W-1:0] cnt_reg;
    logic             issue;
    logic             eval_vld_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    logic             best_found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    slot_entry_t      best_entry_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             eval_ready;
    logic             eval_better;

    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [ID_W-1:0]   task_id_out_reg;
    logic [TIME_W-1:0] remaining_reg;
    logic [TA_W-1:0]   turnaround_reg;
    logic [TIME_W-1:0] tick_time_reg;

    logic [STAT_W-1:0] status_next;
    logic [ID_W-1:0]   task_id_out_next;
    logic [TIME_W-1:0] remaining_next;
    logic [TA_W-1:0]   turnaround_next;
    logic [PRIO_W-1:0] prio_clamped;
    logic              finishes;

    assign issue = dp_cmd.scan && (cnt_reg != CNT_END);
    assign dp_status.scan_done = (cnt_reg == CNT_END);
    assign dp_status.out_free  = !out_valid_reg || out_ready;

    // priority level clamped into 1..levels
    always_comb begin
        prio_clamped = prio_reg;
        if (prio_reg == '0) begin
            prio_clamped = PRIO_W'(1);
        end else if (prio_reg > PRIO_TOP) begin
            prio_clamped = PRIO_TOP;
        end
    end

    // candidate compare, lowest slot wins on equal keys
    always_comb begin
        eval_ready = slot_valid_reg[eval_idx_reg] && (rd_entry_reg.arrival <= time_reg);
        if (use_priority && (rd_entry_reg.priority_lvl != best_entry_reg.priority_lvl)) begin
            eval_better = rd_entry_reg.priority_lvl < best_entry_reg.priority_lvl;
        end else begin
            eval_better = rd_entry_reg.remaining < best_entry_reg.remaining;
        end
    end

    assign finishes = best_entry_reg.remaining <= TIME_W'(1);

    // write port and result values for the finishing cycle
    always_comb begin
        mem_we           = 1'b0;
        mem_waddr        = free_idx_reg;
        mem_wdata        = '{priority_lvl: prio_clamped, remaining: burst_reg,
                             arrival: arrival_reg, task_id: task_id_reg};
        status_next      = STATUS_IDLE;
        task_id_out_next = '0;
        remaining_next   = '0;
        turnaround_next  = '0;
        if (cmd_reg == CMD_ADD) begin
            mem_we      = dp_cmd.finish && free_found_reg;
            status_next = free_found_reg ? STATUS_ADDED : STATUS_FULL;
        end else if (best_found_reg) begin
            task_id_out_next = best_entry_reg.task_id;
            remaining_next   = best_entry_reg.remaining;
            if (finishes) begin
                status_next     = STATUS_FINISHED;
                turnaround_next = {1'b0, time_reg} + TA_W'(1) - {1'b0, best_entry_reg.arrival};
            end else begin
                status_next         = STATUS_RAN;
                mem_we              = dp_cmd.finish;
                mem_waddr           = best_idx_reg;
                mem_wdata           = best_entry_reg;
                mem_wdata.remaining = best_entry_reg.remaining - TIME_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_entry_reg <= mem[cnt_reg[IDX_W-1:0]];
    end

    // latched item and scan payload
    always_ff @(posedge aclk) begin
        if (dp_cmd.start) begin
            cmd_reg     <= in_cmd;
            task_id_reg <= in_task_id;
            arrival_reg <= in_arrival;
            burst_reg   <= in_burst;
            prio_reg    <= in_priority;
        end
        eval_idx_reg <= cnt_reg[IDX_W-1:0];
        if (eval_vld_reg) begin
            if (!slot_valid_reg[eval_idx_reg] && !free_found_reg) begin
                free_idx_reg <= eval_idx_reg;
            end
            if (eval_ready && (!best_found_reg || eval_better)) begin
                best_idx_reg   <= eval_idx_reg;
                best_entry_reg <= rd_entry_reg;
            end
        end
        if (dp_cmd.finish) begin
            status_reg      <= status_next;
            task_id_out_reg <= task_id_out_next;
            remaining_reg   <= remaining_next;
            turnaround_reg  <= turnaround_next;
            tick_time_reg   <= time_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            eval_vld_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            slot_valid_reg <= '0;
            time_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            eval_vld_reg <= issue;
            if (dp_cmd.start) begin
                cnt_reg        <= '0;
                best_found_reg <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (issue) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (eval_vld_reg) begin
                if (!slot_valid_reg[eval_idx_reg]) begin
                    free_found_reg <= 1'b1;
                end
                if (eval_ready) begin
                    best_found_reg <= 1'b1;
                end
            end
            if (dp_cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (dp_cmd.finish) begin
                if (cmd_reg == CMD_ADD) begin
                    if (free_found_reg) begin
                        slot_valid_reg[free_idx_reg] <= 1'b1;
                    end
                end else begin
                    if (best_found_reg && finishes) begin
                        slot_valid_reg[best_idx_reg] <= 1'b0;
                    end
                    if (time_reg != TIME_MAX) begin
                        time_reg <= time_reg + TIME_W'(1);
                    end
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = status_reg;
    assign out_task_id    = task_id_out_reg;
    assign out_remaining  = remaining_reg;
    assign out_turnaround = turnaround_reg;
    assign out_tick_time  = tick_time_reg;

endmodule

[rtl/srtf_task_scheduler_unit.sv]
// top level of the shortest-remaining-time-first task scheduler
// depends on srtf_pkg, srtf_ctrl and srtf_datapath
`timescale 1ns / 1ps

// usage
// - input stream s_*: one beat is either a task add (s_tuser low) or a
//   scheduler tick (s_tuser high); add beats carry id, arrival, burst, level
// - result stream m_*: exactly one beat per input beat, status on m_tuser
// - apb port: one register, use_priority at byte address 0, to be written only
//   while the block is idle; the block itself does not enforce this
// - every beat, add or tick, walks the whole task table one slot a cycle
//   through the single read port of the table memory
// - after acceptance the block scans the whole table, then in its finish state
//   loads the result register that drives m_tvalid
// - one beat at a time: the next beat is taken only once the previous one is
//   finished, while its result may still sit in the output register
// - a stalled receiver holds the result register; the block then waits in
//   its finish cycle until that register drains, nothing is lost
// - reset empties the table, clears time to zero and use_priority to 0;
//   no clearing pass is needed, slot valid bits sit in flip-flops
// - tick time advances after each tick beat and saturates at 65535

module srtf_task_scheduler_unit
    import srtf_pkg::*;
#(
    parameter int TASK_SLOTS      = DEF_TASK_SLOTS,
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // task_id, arrival_time, burst_time, priority_req
    input  logic                 s_tuser,  // cmd
    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // ran_task_id, remaining_before, turnaround, tick_time
    output logic [STAT_W-1:0]    m_tuser,  // status
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    ctrl_cmd_t  dp_cmd;
    dp_status_t dp_status;

    logic use_priority_reg;

    logic [STAT_W-1:0] out_status;
    logic [ID_W-1:0]   out_task_id;
    logic [TIME_W-1:0] out_remaining;
    logic [TA_W-1:0]   out_turnaround;
    logic [TIME_W-1:0] out_tick_time;

    // register file: index is the word address
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_priority_reg <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_USE_PRIORITY)) begin
            use_priority_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_USE_PRIORITY) begin
            prdata[0] = use_priority_reg;
        end
    end

    srtf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    srtf_datapath #(
        .TASK_SLOTS      (TASK_SLOTS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .dp_cmd         (dp_cmd),
        .dp_status      (dp_status),
        .use_priority   (use_priority_reg),
        .in_cmd         (s_tuser),
        .in_task_id     (s_tdata[7:0]),
        .in_arrival     (s_tdata[23:8]),
        .in_burst       (s_tdata[39:24]),
        .in_priority    (s_tdata[43:40]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_status     (out_status),
        .out_task_id    (out_task_id),
        .out_remaining  (out_remaining),
        .out_turnaround (out_turnaround),
        .out_tick_time  (out_tick_time)
    );

    // result beat packing, padding bits held at zero
    assign m_tuser = out_status;
    assign m_tdata = {7'd0, out_tick_time, out_turnaround, out_remaining, out_task_id};

endmodule

[rtl/srtf_checker.sv]
// port-level checks for the srtf task scheduler, bound to the top level
// depends on srtf_pkg for the status codes
`timescale 1ns / 1ps

module srtf_checker
    import srtf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]    m_tuser
);

    // one item in flight: no second beat right after an accepted one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on two consecutive cycles");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= STATUS_FINISHED))
        else $error("unknown status code on result beat");

    // a finished task arrived no later than its last tick
    a_turnaround_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STATUS_FINISHED)) |-> (m_tdata[40:24] != '0))
        else $error("finished task with zero turnaround");

    a_no_run_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_tuser == STATUS_ADDED) || (m_tuser == STATUS_FULL) ||
                      (m_tuser == STATUS_IDLE))) |-> (m_tdata[40:0] == '0))
        else $error("run fields set on a beat without a run task");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat dropped or changed under stall");

endmodule

bind srtf_task_scheduler_unit srtf_checker u_srtf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
